// ===== rtl/conv3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared types and constants of the 3x3 zero padded convolution filter.
// ----------------------------------------------------------------------------
package conv3_pkg;

	// pixel and arithmetic widths
	localparam int PIX_W     = 8;
	localparam int TAP_W     = 5;
	localparam int NUM_TAPS  = 9;
	localparam int GAIN_W    = 16;
	localparam int SUM_W     = 17;
	localparam int PROD_W    = 33;
	localparam int FRAC_BITS = 12;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(2048);
	localparam logic [PROD_W-1:0] PIX_MAX    = PROD_W'(255);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 45;
	localparam int GEOM_W     = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TAPS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd3;

	// register reset values
	localparam logic [GEOM_W-1:0]     RST_IMAGE_WIDTH  = 11'd1024;
	localparam logic [GEOM_W-1:0]     RST_IMAGE_HEIGHT = 11'd1024;
	localparam logic [CFG_DATA_W-1:0] RST_KERNEL_TAPS  = 45'd1048576;
	localparam logic [GAIN_W-1:0]     RST_GAIN         = 16'd4096;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic step;
		logic scale;
		logic load;
	} conv3_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic produced;
	} conv3_status_t;

endpackage
`default_nettype wire

// ===== rtl/conv3_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module conv3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/conv3_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3_ctrl
// Sequencer of the filter: takes one item, steps it through memory read,
// window arithmetic, gain scaling and the output register.
// ----------------------------------------------------------------------------
module conv3_ctrl
	import conv3_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output conv3_cmd_t         cmd,
	input  wire conv3_status_t status
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MAC   = 2'd1;
	localparam logic [1:0] S_SCALE = 2'd2;
	localparam logic [1:0] S_OUT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	// commands to the datapath
	always_comb begin
		cmd.capture = (state_q == S_IDLE) && s_tvalid;
		cmd.step    = (state_q == S_MAC);
		cmd.scale   = (state_q == S_SCALE);
		cmd.load    = (state_q == S_OUT) && out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_MAC;
				end
			end
			S_MAC:   state_d = S_SCALE;
			S_SCALE: state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output valid: set when an item that produced a result is loaded, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= status.produced;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/conv3_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3_datapath
// Configuration registers, position counters, line buffers, 3x3 window,
// weighted sum, gain multiply and clamp with rounding.
// ----------------------------------------------------------------------------
module conv3_datapath
	import conv3_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire conv3_cmd_t            cmd,
	output conv3_status_t              status,
	input  wire logic                  req_type,
	input  wire logic [PIX_W-1:0]      pixel_value,
	output logic      [PIX_W-1:0]      out_pixel,
	output logic                       row_end,
	output logic                       frame_end
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 4);
	localparam int WCMP_W = (WID_W > GEOM_W) ? WID_W : GEOM_W;
	localparam int HCMP_W = (ROW_W > GEOM_W) ? ROW_W : GEOM_W;

	// configuration registers
	logic [GEOM_W-1:0]     width_q;
	logic [GEOM_W-1:0]     height_q;
	logic [CFG_DATA_W-1:0] taps_q;
	logic [GAIN_W-1:0]     gain_q;
	logic                  geom_wr;

	assign geom_wr = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
		(cfg_index == REG_IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			taps_q   <= RST_KERNEL_TAPS;
			gain_q   <= RST_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[GEOM_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[GEOM_W-1:0];
				REG_KERNEL_TAPS:  taps_q   <= cfg_data;
				REG_GAIN:         gain_q   <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry: zero acts as one, oversize saturates
	logic [WCMP_W-1:0] width_ext;
	logic [HCMP_W-1:0] height_ext;
	logic [WID_W-1:0]  w_eff;
	logic [ROW_W-1:0]  h_eff;

	assign width_ext  = WCMP_W'(width_q);
	assign height_ext = HCMP_W'(height_q);

	always_comb begin
		if (width_ext == '0) begin
			w_eff = WID_W'(1);
		end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(width_ext);
		end
		if (height_ext == '0) begin
			h_eff = ROW_W'(1);
		end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
			h_eff = ROW_W'(MAX_HEIGHT);
		end else begin
			h_eff = ROW_W'(height_ext);
		end
	end

	// input position counters
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// captured pixel, drain items and rows past the image read as zero
	logic [PIX_W-1:0] pix_s1;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_s1 <= (!req_type && (row_q < h_eff)) ? pixel_value : '0;
		end
	end

	// line buffers: row-2 and row-1
	logic [PIX_W-1:0] line0_rd;
	logic [PIX_W-1:0] line1_rd;

	conv3_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line0 (
		.clk  (clk),
		.we   (cmd.step),
		.waddr(col_q),
		.wdata(line1_rd),
		.raddr(col_q),
		.rdata(line0_rd)
	);

	conv3_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line1 (
		.clk  (clk),
		.we   (cmd.step),
		.waddr(col_q),
		.wdata(pix_s1),
		.raddr(col_q),
		.rdata(line1_rd)
	);

	// window: two older columns for each of the three rows
	logic [PIX_W-1:0] win_q [6];
	logic [PIX_W-1:0] cur [3];

	assign cur[0] = line0_rd;
	assign cur[1] = line1_rd;
	assign cur[2] = pix_s1;

	// neighbourhood masks
	logic       col_zero;
	logic       produce;
	logic       frame_last;
	logic [3:0] rk_ok;
	logic [2:0] row_ok;
	logic [2:0] col_ok;

	always_comb begin
		col_zero   = (col_q == '0);
		produce    = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && !col_zero);
		frame_last = col_zero && (row_q == h_eff + ROW_W'(1));
		for (int k = 0; k < 4; k++) begin
			rk_ok[k] = (row_q >= ROW_W'(k)) && (row_q < h_eff + ROW_W'(k));
		end
		for (int i = 0; i < 3; i++) begin
			row_ok[i] = col_zero ? rk_ok[3-i] : rk_ok[2-i];
		end
		col_ok[0] = col_zero ? (w_eff >= WID_W'(2)) : (col_q >= COL_W'(2));
		col_ok[1] = 1'b1;
		col_ok[2] = !col_zero;
	end

	// weighted sum of the masked neighbourhood
	logic signed [SUM_W-1:0] sum;

	always_comb begin
		logic signed [TAP_W-1:0] tap;
		logic        [PIX_W-1:0] nb;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				tap = signed'(taps_q[TAP_W*(3*i+j) +: TAP_W]);
				if (j == 2) begin
					nb = cur[i];
				end else begin
					nb = win_q[2*i+j];
				end
				if (row_ok[i] && col_ok[j]) begin
					sum = sum + SUM_W'(tap) * signed'(SUM_W'(nb));
				end
			end
		end
	end

	// next input position
	logic [WID_W-1:0] col_inc;

	assign col_inc = WID_W'(col_q) + WID_W'(1);

	logic signed [SUM_W-1:0] sum_s2;
	logic                    produced_s2;
	logic                    row_end_s2;
	logic                    frame_end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (geom_wr) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.step) begin
			for (int i = 0; i < 3; i++) begin
				win_q[2*i]   <= win_q[2*i+1];
				win_q[2*i+1] <= cur[i];
			end
			if (frame_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= COL_W'(col_inc);
			end
		end
	end

	// sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			produced_s2 <= 1'b0;
		end else if (cmd.step) begin
			produced_s2 <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			sum_s2       <= sum;
			row_end_s2   <= col_zero;
			frame_end_s2 <= frame_last;
		end
	end

	assign status.produced = produced_s2;

	// gain stage
	logic signed [PROD_W-1:0] prod_s3;

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			prod_s3 <= PROD_W'(sum_s2) * signed'(PROD_W'(gain_q));
		end
	end

	// clamp and round half up
	logic [PROD_W-1:0] rnd;
	logic [PROD_W-1:0] scaled;
	logic [PIX_W-1:0]  res;

	always_comb begin
		rnd    = unsigned'(prod_s3) + ROUND_HALF;
		scaled = rnd >> FRAC_BITS;
		if (prod_s3 <= 0) begin
			res = '0;
		end else if (scaled > PIX_MAX) begin
			res = PIX_MAX[PIX_W-1:0];
		end else begin
			res = scaled[PIX_W-1:0];
		end
	end

	// output register
	logic [PIX_W-1:0] out_pixel_q;
	logic             row_end_q;
	logic             frame_end_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_pixel_q <= res;
			row_end_q   <= row_end_s2;
			frame_end_q <= frame_end_s2;
		end
	end

	assign out_pixel = out_pixel_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

endmodule
`default_nettype wire

// ===== rtl/conv3x3_zero_pad_filter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_filter_unit
// 3x3 convolution of an 8-bit grayscale raster stream with zero padding.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and each image position yields one filtered
// pixel, width+1 items after its centre pixel; after the last pixel of a frame
// send width+1 drain items (tuser high) to flush the remaining outputs. The
// result is the correlation with nine signed 5-bit taps, scaled by a Q4.12
// gain, clamped to 0..255 and rounded half up. An accepted item passes
// through the line buffer read, the window sum and the gain multiply, with
// the clamp in front of the output register. The next item is accepted in
// the cycle after the previous one has entered the output register, so a new
// item is never taken while the previous one is still in flight, and a
// result left waiting stalls the input once the following item has been
// computed. Writing the width or height restarts the frame.
// ----------------------------------------------------------------------------
module conv3x3_zero_pad_filter_unit
	import conv3_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input items
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [7:0] pixel_value
	input  wire logic                  s_tuser,   // [0] req_type
	// result items
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [7:0]            m_tdata,   // [7:0] out_pixel
	output logic                       m_tlast,   // row_end
	output logic                       m_tuser    // [0] frame_end
);

	conv3_cmd_t    cmd;
	conv3_status_t status;

	conv3_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.status  (status)
	);

	conv3_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.status     (status),
		.req_type   (s_tuser),
		.pixel_value(s_tdata),
		.out_pixel  (m_tdata),
		.row_end    (m_tlast),
		.frame_end  (m_tuser)
	);

endmodule
`default_nettype wire
